// ===== hw/rtl/sld_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the scanline lane center detector.
// Used by sld_run_tracker and scanline_lane_center_detector_core; no dependencies.
package sld_pkg;

  localparam int unsigned PixW = 8;
  localparam int unsigned PosW = 12;
  localparam int unsigned LineCntW = 10;

  // Register indexes of the configuration port
  typedef enum logic [1:0] {
    CFG_SIDE     = 2'd0,
    CFG_LANE     = 2'd1,
    CFG_SHOULDER = 2'd2
  } cfg_idx_e;

  // Direction codes
  localparam logic [1:0] DIR_NONE     = 2'd0;
  localparam logic [1:0] DIR_STRAIGHT = 2'd1;
  localparam logic [1:0] DIR_LEFT     = 2'd2;
  localparam logic [1:0] DIR_RIGHT    = 2'd3;

  typedef struct packed {
    logic [PixW-1:0] side;
    logic [PixW-1:0] lane;
    logic [PixW-1:0] shoulder;
  } cfg_t;

  // Per-line status after the current pixel has been applied
  typedef struct packed {
    logic            matched;
    logic [PosW-1:0] midpoint;
  } line_status_t;

  typedef struct packed {
    logic            lane_found;
    logic [PosW-1:0] midpoint;
    logic            dir_valid;
    logic [1:0]      direction;
  } result_t;

endpackage

// ===== hw/rtl/sld_run_tracker.sv =====
`timescale 1ns / 1ps
// Run-length tracker for one scanline: keeps the last runs and latches the lane center.
// Depends on sld_pkg.
module sld_run_tracker #(
  parameter int unsigned LINE_WIDTH = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic [sld_pkg::PixW-1:0]     pixel_i,
  input  logic                         end_i,
  input  sld_pkg::cfg_t                cfg_i,
  output sld_pkg::line_status_t        status_o
);

  localparam int unsigned PosMaxInt = (LINE_WIDTH - 1 < 4095) ? (LINE_WIDTH - 1) : 4095;
  localparam logic [sld_pkg::PosW-1:0] PosMax = sld_pkg::PosW'(PosMaxInt);

  logic [sld_pkg::PosW-1:0] pos_q, pos_d;
  logic [sld_pkg::PixW-1:0] cur_q, cur_d;
  logic [sld_pkg::PixW-1:0] vh_q [4];
  logic [sld_pkg::PixW-1:0] vh_d [4];
  logic [sld_pkg::PosW-1:0] sh_q [3];
  logic [sld_pkg::PosW-1:0] sh_d [3];
  logic [2:0]               cnt_q, cnt_d;
  logic                     matched_q, matched_d;
  logic [sld_pkg::PosW-1:0] mid_q, mid_d;

  logic                     hit;
  logic [sld_pkg::PosW-1:0] lane_start;
  logic [sld_pkg::PosW-1:0] start_m1;
  logic [sld_pkg::PosW:0]   len_p1;
  logic [sld_pkg::PosW:0]   center;

  // Lane geometry from the stored run starts (starts never decrease on a line)
  assign lane_start = sh_q[1];
  assign start_m1   = (lane_start != '0) ? lane_start - 1'b1 : '0;
  assign len_p1     = {1'b0, sh_q[2] - sh_q[1]} + 1'b1;
  assign center     = {1'b0, start_m1} + {1'b0, len_p1[sld_pkg::PosW:1]};

  // Pattern shoulder, side, lane, side closes as a new shoulder run starts
  assign hit = !matched_q && (cnt_q >= 3'd3) &&
               (vh_q[1] == cfg_i.shoulder) && (vh_q[2] == cfg_i.side) &&
               (vh_q[3] == cfg_i.lane) && (cur_q == cfg_i.side) &&
               (pixel_i == cfg_i.shoulder);

  always_comb begin
    pos_d     = pos_q;
    cur_d     = cur_q;
    vh_d      = vh_q;
    sh_d      = sh_q;
    cnt_d     = cnt_q;
    matched_d = matched_q;
    mid_d     = mid_q;
    if (pos_q == '0) begin
      cur_d     = pixel_i;
      sh_d[2]   = '0;
      cnt_d     = '0;
      matched_d = 1'b0;
      mid_d     = '0;
    end else if (pixel_i != cur_q) begin
      vh_d[0] = vh_q[1];
      vh_d[1] = vh_q[2];
      vh_d[2] = vh_q[3];
      vh_d[3] = cur_q;
      sh_d[0] = sh_q[1];
      sh_d[1] = sh_q[2];
      sh_d[2] = pos_q;
      if (cnt_q < 3'd4) begin
        cnt_d = cnt_q + 1'b1;
      end
      cur_d = pixel_i;
      if (hit) begin
        matched_d = 1'b1;
        mid_d     = center[sld_pkg::PosW] ? '1 : center[sld_pkg::PosW-1:0];
      end
    end
    if (!end_i && pos_q < PosMax) begin
      pos_d = pos_q + 1'b1;
    end
  end

  assign status_o.matched  = matched_d;
  assign status_o.midpoint = mid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      cur_q     <= '0;
      cnt_q     <= '0;
      matched_q <= 1'b0;
      mid_q     <= '0;
      for (int i = 0; i < 4; i++) vh_q[i] <= '0;
      for (int i = 0; i < 3; i++) sh_q[i] <= '0;
    end else if (step_i) begin
      if (end_i) begin
        pos_q     <= '0;
        cur_q     <= '0;
        cnt_q     <= '0;
        matched_q <= 1'b0;
        mid_q     <= '0;
        for (int i = 0; i < 4; i++) vh_q[i] <= '0;
        for (int i = 0; i < 3; i++) sh_q[i] <= '0;
      end else begin
        pos_q     <= pos_d;
        cur_q     <= cur_d;
        cnt_q     <= cnt_d;
        matched_q <= matched_d;
        mid_q     <= mid_d;
        vh_q      <= vh_d;
        sh_q      <= sh_d;
      end
    end
  end

endmodule

// ===== hw/rtl/scanline_lane_center_detector_core.sv =====
`timescale 1ns / 1ps
// Top level of the scanline lane center detector: frame statistics, direction, output stage.
// Depends on sld_pkg and sld_run_tracker.

// One pixel is taken per clock, with no gaps needed: the run tracker updates its state in the
// same cycle a pixel transfer completes, and a line-end pixel loads the one-per-line result into
// the output register, or the skid register while output is held. A two-entry output stage
// (output register plus skid register) lets pixels keep flowing while a result waits; in_stall_o
// rises only once both entries are full, i.e. a second line result arrives while the first is
// still held. Pixels that do not end a line never produce a result. Each line result carries
// the found flag and the lane center; the frame's last line result (frame_end, which also ends
// the line) adds the direction estimate comparing the frame's last found center with its first
// one. Position and line counters saturate. Configuration writes are always ready and take
// effect for the next pixel; they are meant to be done while the block is idle.
module scanline_lane_center_detector_core #(
  parameter int unsigned LINE_WIDTH = 4096,
  parameter int unsigned MAX_LINES  = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [1:0]                        cfg_index_i,
  input  logic [sld_pkg::PixW-1:0]          cfg_data_i,
  // pixel channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [sld_pkg::PixW-1:0]          in_pixel_i,
  input  logic                              in_line_end_i,
  input  logic                              in_frame_end_i,
  // line result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              out_lane_found_o,
  output logic [sld_pkg::PosW-1:0]          out_midpoint_o,
  output logic                              out_direction_valid_o,
  output logic [1:0]                        out_direction_o
);

  localparam int unsigned LineMaxInt = (MAX_LINES < 1023) ? MAX_LINES : 1023;
  localparam logic [sld_pkg::LineCntW-1:0] LineMax = sld_pkg::LineCntW'(LineMaxInt);

  // ---------------------------------------------------------------- configuration
  sld_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.side     <= 8'd255;
      cfg_q.lane     <= 8'd128;
      cfg_q.shoulder <= 8'd0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == sld_pkg::CFG_SIDE)     cfg_q.side     <= cfg_data_i;
      if (cfg_index_i == sld_pkg::CFG_LANE)     cfg_q.lane     <= cfg_data_i;
      if (cfg_index_i == sld_pkg::CFG_SHOULDER) cfg_q.shoulder <= cfg_data_i;
    end
  end

  // ---------------------------------------------------------------- pixel transfer
  logic in_fire;
  logic line_done;

  assign in_fire   = in_valid_i && !in_stall_o;
  assign line_done = in_line_end_i || in_frame_end_i;  // frame end also closes the line

  // ---------------------------------------------------------------- per-line run tracking
  sld_pkg::line_status_t line_st;

  sld_run_tracker #(
    .LINE_WIDTH(LINE_WIDTH)
  ) u_run_tracker (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (in_fire),
    .pixel_i (in_pixel_i),
    .end_i   (line_done),
    .cfg_i   (cfg_q),
    .status_o(line_st)
  );

  // ---------------------------------------------------------------- frame statistics
  logic [sld_pkg::LineCntW-1:0] seen_q, seen_d;
  logic [sld_pkg::LineCntW-1:0] found_q, found_d;
  logic [sld_pkg::PosW-1:0]     first_q, first_d;
  logic [sld_pkg::PosW-1:0]     last_q, last_d;

  always_comb begin
    seen_d  = (seen_q < LineMax) ? seen_q + 1'b1 : seen_q;
    found_d = found_q;
    first_d = first_q;
    last_d  = last_q;
    if (line_st.matched) begin
      if (found_q == '0) first_d = line_st.midpoint;
      last_d = line_st.midpoint;
      if (found_q < LineMax) found_d = found_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= '0;
      found_q <= '0;
      first_q <= '0;
      last_q  <= '0;
    end else if (in_fire && line_done) begin
      if (in_frame_end_i) begin
        seen_q  <= '0;
        found_q <= '0;
        first_q <= '0;
        last_q  <= '0;
      end else begin
        seen_q  <= seen_d;
        found_q <= found_d;
        first_q <= first_d;
        last_q  <= last_d;
      end
    end
  end

  // ---------------------------------------------------------------- direction estimate
  // Enough lines found when 10*found >= 7*seen; straight when 0.8 <= last/first <= 1.2,
  // both tested by cross-multiplying with small constants.
  logic [13:0] found_x10, seen_x7;
  logic [15:0] last_x10, first_x8, first_x12;
  logic [1:0]  dir;

  assign found_x10 = 14'(found_d) * 14'd10;
  assign seen_x7   = 14'(seen_d) * 14'd7;
  assign last_x10  = 16'(last_d) * 16'd10;
  assign first_x8  = 16'(first_d) * 16'd8;
  assign first_x12 = 16'(first_d) * 16'd12;

  always_comb begin
    if (found_d == '0 || found_x10 < seen_x7) begin
      dir = sld_pkg::DIR_NONE;
    end else if (last_x10 <= first_x12 && last_x10 >= first_x8) begin
      dir = sld_pkg::DIR_STRAIGHT;
    end else if (first_d < last_d) begin
      dir = sld_pkg::DIR_LEFT;
    end else begin
      dir = sld_pkg::DIR_RIGHT;
    end
  end

  sld_pkg::result_t res;

  assign res.lane_found = line_st.matched;
  assign res.midpoint   = line_st.matched ? line_st.midpoint : '0;
  assign res.dir_valid  = in_frame_end_i;
  assign res.direction  = in_frame_end_i ? dir : sld_pkg::DIR_NONE;

  // ---------------------------------------------------------------- output stage
  // Output register plus one skid entry; the skid only fills while the output is held.
  logic             res_vld;
  logic             out_vld_q, skid_vld_q;
  sld_pkg::result_t out_q, skid_q;
  logic             out_free;

  assign res_vld    = in_fire && line_done;
  assign out_free   = !out_vld_q || !out_stall_i;
  assign in_stall_o = skid_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_free) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q <= res_vld;
      end
    end else if (res_vld) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_vld_q) out_q <= skid_q;
      else if (res_vld) out_q <= res;
    end else if (res_vld) begin
      skid_q <= res;
    end
  end

  assign out_valid_o           = out_vld_q;
  assign out_lane_found_o      = out_q.lane_found;
  assign out_midpoint_o        = out_q.midpoint;
  assign out_direction_valid_o = out_q.dir_valid;
  assign out_direction_o       = out_q.direction;

  // ---------------------------------------------------------------- assertions
  // skid entry is only ever occupied behind a held output
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry valid while output register empty");

  // found lines can never exceed lines seen in the frame
  a_found_le_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q <= seen_q)
    else $error("found line count exceeds line count");

  // a line without a lane reports a zero center
  a_mid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_q.lane_found) |-> (out_q.midpoint == '0))
    else $error("midpoint nonzero on a line without lane");

  // direction is only reported on a frame's last line
  a_dir_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_q.dir_valid) |-> (out_q.direction == sld_pkg::DIR_NONE))
    else $error("direction set outside frame end");

endmodule
